// ----- rtl/core/vtp_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// vtp_pkg: shared types and constants of the terminal stream parser
// Holds the field widths, the op codes and the command record used by the
// decoder and the output queue.
// ----------------------------------------------------------------------------
package vtp_pkg;

  localparam int unsigned ColumnsDef   = 40;
  localparam int unsigned RowsDef      = 28;
  localparam int unsigned MaxSeqLenDef = 20;

  localparam int unsigned ColW = 6;
  localparam int unsigned RowW = 5;

  localparam logic [5:0] OriginReset = 6'd2;

  typedef enum logic [2:0] {
    OP_GLYPH  = 3'd0,
    OP_SCRUP  = 3'd1,
    OP_SCRDN  = 3'd2,
    OP_CLEAR  = 3'd3,
    OP_ERASE  = 3'd4,
    OP_DELETE = 3'd5,
    OP_CURVIS = 3'd6,
    OP_MOVED  = 3'd7
  } op_e;

  // parser phases, one-hot
  typedef enum logic [7:0] {
    PH_GROUND = 8'b0000_0001,
    PH_ESC    = 8'b0000_0010,
    PH_CSI    = 8'b0000_0100,
    PH_OSC    = 8'b0000_1000,
    PH_SKIP   = 8'b0001_0000,
    PH_IAC    = 8'b0010_0000,
    PH_UTF1   = 8'b0100_0000,
    PH_UTF2   = 8'b1000_0000
  } phase_e;

  localparam logic [7:0] ChEsc    = 8'd27;
  localparam logic [7:0] ChIac    = 8'hff;
  localparam logic [7:0] ChUtf    = 8'he2;
  localparam logic [7:0] ChUtfC1  = 8'h80;
  localparam logic [7:0] ChUtfC2  = 8'ha2;
  localparam logic [7:0] ChSb     = 8'd250;
  localparam logic [7:0] GlBullet = 8'd128;
  localparam logic [7:0] GlOther  = 8'd129;

  // one display command plus the cursor after the byte
  typedef struct packed {
    op_e        op;
    logic [5:0] column;
    logic [4:0] row;
    logic [7:0] glyph;
    logic [5:0] span_end;
    logic [5:0] cursor_col;
    logic [4:0] cursor_row;
    logic       last;
  } cmd_t;

  // up to two commands per byte
  typedef struct packed {
    logic [1:0] cnt;
    cmd_t       c0;
    cmd_t       c1;
  } cmd_pair_t;

endpackage
`default_nettype wire

// ----- rtl/core/vtp_stream_if.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// vtp_stream_if: valid/ready channel
// Generic payload channel with source and sink views.
// ----------------------------------------------------------------------------
interface vtp_stream_if #(
  parameter type payload_t = logic [7:0]
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// ----- rtl/core/vt100_stream_cursor_parser.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// vt100_stream_cursor_parser: terminal byte stream parser
// Path: the decoder is combinational and the commands of an accepted byte are
// registered in the output queue, behind any commands still waiting there.
// Throughput: one byte per cycle through the combinational decoder while the
// four-entry queue has two free slots; a byte making two commands fills both.
// Reset: ground state, cursor at column 2 row 0, autowrap off, origin 2.
// ----------------------------------------------------------------------------
module vt100_stream_cursor_parser #(
  parameter int unsigned Columns   = vtp_pkg::ColumnsDef,
  parameter int unsigned Rows      = vtp_pkg::RowsDef,
  parameter int unsigned MaxSeqLen = vtp_pkg::MaxSeqLenDef
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  vtp_stream_if.sink   cfg,
  vtp_stream_if.sink   rx,
  vtp_stream_if.source res
);
  import vtp_pkg::*;

  logic [5:0] origin_q;
  logic       room, take;
  cmd_pair_t  cmds;
  cmd_t       head;

  // configuration register
  assign cfg.ready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) origin_q <= OriginReset;
    else if (cfg.valid) origin_q <= cfg.data[5:0];
  end

  assign rx.ready = room;
  assign take     = rx.valid && room;

  vtp_decode #(.Columns(Columns), .Rows(Rows), .MaxSeqLen(MaxSeqLen)) u_dec (
    .clk_i, .rst_ni, .en_i(take), .byte_i(rx.data[7:0]), .origin_i(origin_q),
    .cmds_o(cmds)
  );

  vtp_outq u_q (
    .clk_i, .rst_ni, .push_i(cmds), .room_o(room),
    .valid_o(res.valid), .ready_i(res.ready), .head_o(head)
  );

  assign res.data = head;

endmodule
`default_nettype wire

// ----- rtl/core/vtp_decode.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// vtp_decode: byte decoder and cursor state
// Takes one byte per cycle when enabled, updates the parse state and cursor
// and produces zero, one or two display commands.
// ----------------------------------------------------------------------------
module vtp_decode #(
  parameter int unsigned Columns   = vtp_pkg::ColumnsDef,
  parameter int unsigned Rows      = vtp_pkg::RowsDef,
  parameter int unsigned MaxSeqLen = vtp_pkg::MaxSeqLenDef
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               en_i,
  input  wire logic [7:0]         byte_i,
  input  wire logic [5:0]         origin_i,
  output vtp_pkg::cmd_pair_t      cmds_o
);
  import vtp_pkg::*;

  localparam logic [6:0] ColLast = 7'(Columns - 1);
  localparam logic [6:0] ColEnd  = 7'(Columns);
  localparam logic [5:0] RowLast = 6'(Rows - 1);
  localparam logic [4:0] SeqMax  = 5'(MaxSeqLen);

  phase_e     phase_q, phase_d;
  logic [7:0] pfx_q [3];
  logic [7:0] pfx_d [3];
  logic [4:0] len_q, len_d;
  logic [7:0] p1_q, p1_d, p2_q, p2_d;
  logic       pidx_q, pidx_d;
  logic [5:0] col_q, col_d;
  logic [4:0] row_q, row_d;
  logic       wrap_q, wrap_d;
  logic [2:0] skip_q, skip_d;
  logic [7:0] utf_q, utf_d;

  // command builder scratch
  cmd_t       e0, e1;
  logic [1:0] n;
  logic [5:0] org;
  logic [4:0] len_n;
  logic [11:0] acc;
  logic [8:0] v;
  logic [7:0] glyph_v;
  logic       do_glyph;
  logic [2:0] skip_m;

  always_comb begin
    org = ({1'b0, origin_i} > ColLast) ? ColLast[5:0] : origin_i;
  end

  always_comb begin
    phase_d = phase_q;
    pfx_d   = pfx_q;
    len_d   = len_q;
    p1_d    = p1_q;
    p2_d    = p2_q;
    pidx_d  = pidx_q;
    col_d   = col_q;
    row_d   = row_q;
    wrap_d  = wrap_q;
    skip_d  = skip_q;
    utf_d   = utf_q;
    e0      = '0;
    e1      = '0;
    n       = 2'd0;
    len_n   = len_q;
    acc     = '0;
    v       = '0;
    glyph_v = byte_i;
    do_glyph = 1'b0;
    skip_m  = skip_q;

    case (phase_q)
      PH_GROUND: begin
        if (byte_i == ChEsc) phase_d = PH_ESC;
        else if (byte_i == ChIac) phase_d = PH_IAC;
        else if (byte_i == ChUtf) phase_d = PH_UTF1;
        else if (byte_i == 8'd8) begin
          if (col_q > org) col_d = col_q - 6'd1;
          e0.op = OP_MOVED; n = 2'd1;
        end else if (byte_i == 8'd10) begin
          if ({1'b0, row_q} >= RowLast) begin
            row_d = RowLast[4:0];
            e0.op = OP_SCRUP;
          end else begin
            row_d = row_q + 5'd1;
            e0.op = OP_MOVED;
          end
          n = 2'd1;
        end else if (byte_i == 8'd12) begin
          col_d = org; row_d = '0;
          e0.op = OP_CLEAR; n = 2'd1;
        end else if (byte_i == 8'd13) begin
          col_d = org;
          e0.op = OP_MOVED; n = 2'd1;
        end else if (byte_i >= 8'd32 && byte_i <= 8'd129) begin
          do_glyph = 1'b1;
        end
      end
      PH_ESC: begin
        if (byte_i == "[") begin
          phase_d = PH_CSI;
          pfx_d   = '{default: 8'd0};
          len_d   = '0; p1_d = '0; p2_d = '0; pidx_d = 1'b0;
        end else if (byte_i == "]") phase_d = PH_OSC;
        else if (byte_i == "(" || byte_i == ")") begin
          skip_d = 3'd1; phase_d = PH_SKIP;
        end else phase_d = PH_GROUND;
      end
      PH_CSI: begin
        if (len_q < 5'd3) pfx_d[len_q[1:0]] = byte_i;
        if (len_q < SeqMax) len_n = len_q + 5'd1;
        len_d = len_n;
        if (byte_i >= "A" && byte_i <= "z") begin
          phase_d = PH_GROUND;
          case (byte_i)
            "A": begin
              if (row_q != '0) row_d = row_q - 5'd1;
              e0.op = OP_MOVED; n = 2'd1;
            end
            "B": begin
              if ({1'b0, row_q} < RowLast) row_d = row_q + 5'd1;
              e0.op = OP_MOVED; n = 2'd1;
            end
            "C": begin
              v = {3'd0, col_q} + ((len_n == 5'd1) ? 9'd1 : {1'b0, p1_q});
              col_d = (v > {2'b0, ColLast}) ? ColLast[5:0] : v[5:0];
              e0.op = OP_MOVED; n = 2'd1;
            end
            "D": begin
              if (col_q > org) col_d = col_q - 6'd1;
              e0.op = OP_MOVED; n = 2'd1;
            end
            "H", "f": begin
              if (len_n == 5'd1) begin
                col_d = org; row_d = '0;
              end else begin
                v = (p1_q == '0) ? 9'd0 : {1'b0, p1_q} - 9'd1;
                row_d = (v > {3'b0, RowLast}) ? RowLast[4:0] : v[4:0];
                v = (p2_q == '0) ? {3'd0, org} : {1'b0, p2_q} - 9'd1 + {3'd0, org};
                col_d = (v > {2'b0, ColLast}) ? ColLast[5:0] : v[5:0];
              end
              e0.op = OP_MOVED; n = 2'd1;
            end
            "J": begin
              e0.op = OP_CLEAR; n = 2'd1;
            end
            "K": begin
              e0.op  = OP_ERASE;
              e0.row = row_q;
              if (len_n == 5'd1 || pfx_d[0] == "0") begin
                e0.column = col_q; e0.span_end = ColEnd[5:0];
                n = ({1'b0, col_q} < ColEnd) ? 2'd1 : 2'd0;
              end else if (pfx_d[0] == "1") begin
                e0.span_end = ({1'b0, col_q} > ColEnd) ? ColEnd[5:0] : col_q;
                n = (e0.span_end != '0) ? 2'd1 : 2'd0;
              end else if (pfx_d[0] == "2") begin
                e0.span_end = ColEnd[5:0]; n = 2'd1;
              end
            end
            "P": begin
              if ((pfx_d[0] == "1" || len_n == 5'd1) && col_q > org) begin
                e0.op = OP_DELETE;
                e0.column = ({1'b0, col_q} > ColLast) ? ColLast[5:0] : col_q;
                e0.row = row_q; n = 2'd1;
              end
            end
            "S": begin
              e0.op = OP_SCRUP; n = 2'd1;
            end
            "T": begin
              e0.op = OP_SCRDN; n = 2'd1;
            end
            "h", "l": begin
              if (pfx_d[0] == "?") begin
                if (pfx_d[1] == "2" && pfx_d[2] == "5") begin
                  e0.op = OP_CURVIS; e0.glyph = {7'd0, byte_i == "h"}; n = 2'd1;
                end else if (pfx_d[1] == "7") wrap_d = (byte_i == "h");
              end
            end
            default: ;
          endcase
        end else if (byte_i >= "0" && byte_i <= "9") begin
          // times ten plus digit; 255 * 10 + 9 fits in 12 bits
          acc = (pidx_q ? {4'b0, p2_q} : {4'b0, p1_q});
          acc = (acc << 3) + (acc << 1) + {8'd0, byte_i[3:0]};
          if (pidx_q) p2_d = (acc > 12'd255) ? 8'd255 : acc[7:0];
          else        p1_d = (acc > 12'd255) ? 8'd255 : acc[7:0];
        end else if (byte_i == ";") pidx_d = 1'b1;
      end
      PH_OSC: begin
        if (byte_i == 8'd7) phase_d = PH_GROUND;
      end
      PH_SKIP: begin
        if (skip_q != '0) skip_m = skip_q - 3'd1;
        skip_d = skip_m;
        if (skip_m == '0) phase_d = PH_GROUND;
      end
      PH_IAC: begin
        skip_d  = (byte_i == ChSb) ? 3'd4 : 3'd1;
        phase_d = PH_SKIP;
      end
      PH_UTF1: begin
        utf_d = byte_i; phase_d = PH_UTF2;
      end
      PH_UTF2: begin
        phase_d  = PH_GROUND;
        glyph_v  = (utf_q == ChUtfC1 && byte_i == ChUtfC2) ? GlBullet : GlOther;
        do_glyph = 1'b1;
      end
      default: phase_d = PH_GROUND;
    endcase

    // glyph placement with optional wrap and scroll
    if (do_glyph) begin
      if ({1'b0, col_q} < ColEnd) begin
        e0.op = OP_GLYPH; e0.column = col_q; e0.row = row_q; e0.glyph = glyph_v;
        col_d = col_q + 6'd1; n = 2'd1;
      end else if (wrap_q) begin
        if ({1'b0, row_q} >= RowLast) begin
          row_d = RowLast[4:0];
          e0.op = OP_SCRUP;
          e1.op = OP_GLYPH; e1.column = org; e1.row = RowLast[4:0]; e1.glyph = glyph_v;
          n = 2'd2;
        end else begin
          row_d = row_q + 5'd1;
          e0.op = OP_GLYPH; e0.column = org; e0.row = row_q + 5'd1; e0.glyph = glyph_v;
          n = 2'd1;
        end
        col_d = org + 6'd1;
      end
    end

    // cursor-moved reports carry the new position
    if (n != '0 && e0.op == OP_MOVED) begin
      e0.column = col_d; e0.row = row_d;
    end
    e0.cursor_col = col_d; e0.cursor_row = row_d; e0.last = (n == 2'd1);
    e1.cursor_col = col_d; e1.cursor_row = row_d; e1.last = 1'b1;
  end

  assign cmds_o.cnt = en_i ? n : 2'd0;
  assign cmds_o.c0  = e0;
  assign cmds_o.c1  = e1;

  // parse and cursor state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_GROUND;
      pfx_q   <= '{default: 8'd0};
      len_q   <= '0;
      p1_q    <= '0;
      p2_q    <= '0;
      pidx_q  <= 1'b0;
      col_q   <= OriginReset;
      row_q   <= '0;
      wrap_q  <= 1'b0;
      skip_q  <= '0;
      utf_q   <= '0;
    end else if (en_i) begin
      phase_q <= phase_d;
      pfx_q   <= pfx_d;
      len_q   <= len_d;
      p1_q    <= p1_d;
      p2_q    <= p2_d;
      pidx_q  <= pidx_d;
      col_q   <= col_d;
      row_q   <= row_d;
      wrap_q  <= wrap_d;
      skip_q  <= skip_d;
      utf_q   <= utf_d;
    end
  end

  // cursor stays on screen, allowing the pending-wrap column
  assert property (@(posedge clk_i) disable iff (!rst_ni) {1'b0, col_q} <= ColEnd)
    else $error("cursor column beyond pending-wrap column");
  assert property (@(posedge clk_i) disable iff (!rst_ni) {1'b0, row_q} <= RowLast)
    else $error("cursor row beyond last row");
  assert property (@(posedge clk_i) disable iff (!rst_ni) $onehot(phase_q))
    else $error("parse phase not one-hot");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_SKIP) |-> (skip_q != '0))
    else $error("skip phase with no bytes left");

endmodule
`default_nettype wire

// ----- rtl/core/vtp_outq.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// vtp_outq: result queue
// Four-entry command queue; ready is given while two free slots remain so a
// byte that makes two commands always fits.
// ----------------------------------------------------------------------------
module vtp_outq (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  vtp_pkg::cmd_pair_t push_i,
  output logic               room_o,
  output logic               valid_o,
  input  wire logic          ready_i,
  output vtp_pkg::cmd_t      head_o
);
  import vtp_pkg::*;

  cmd_t       mem_q [4];
  logic [1:0] rd_q, wr_q;
  logic [2:0] cnt_q;
  logic       pop;

  assign pop     = valid_o && ready_i;
  assign valid_o = (cnt_q != '0);
  assign head_o  = mem_q[rd_q];
  assign room_o  = (cnt_q <= 3'd2);

  always_ff @(posedge clk_i) begin
    if (push_i.cnt != '0) mem_q[wr_q] <= push_i.c0;
    if (push_i.cnt == 2'd2) mem_q[wr_q + 2'd1] <= push_i.c1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_q <= '0; wr_q <= '0; cnt_q <= '0;
    end else begin
      wr_q  <= wr_q + push_i.cnt;
      if (pop) rd_q <= rd_q + 2'd1;
      cnt_q <= cnt_q + {1'b0, push_i.cnt} - {2'b0, pop};
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q <= 3'd4)
    else $error("queue overflow");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i.cnt != '0) |-> room_o)
    else $error("push without room");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == '0) |-> !valid_o)
    else $error("empty queue shows valid");

endmodule
`default_nettype wire
